FILE: hdl/ast_pkg.sv
// Shared types and constants of the alarm schedule table.
package ast_pkg;

	localparam logic [11:0] YEAR_FLOOR = 12'd2020;
	localparam logic [6:0]  MINUTE_NONE = 7'd127;
	localparam logic [2:0]  WEEKDAYS = 3'd7;

	typedef enum logic [1:0] {
		KIND_TICK   = 2'd0,
		KIND_ADD    = 2'd1,
		KIND_DELETE = 2'd2,
		KIND_ENABLE = 2'd3
	} ast_kind_t;

	typedef enum logic [3:0] {
		CMD_POWER_ON   = 4'd0,
		CMD_POWER_OFF  = 4'd1,
		CMD_FILTER_ON  = 4'd2,
		CMD_FILTER_OFF = 4'd3,
		CMD_HEATER_ON  = 4'd4,
		CMD_HEATER_OFF = 4'd5,
		CMD_BUBBLE_ON  = 4'd6,
		CMD_BUBBLE_OFF = 4'd7,
		CMD_SET_TEMP   = 4'd8,
		CMD_STATUS     = 4'd9
	} ast_cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2
	} ast_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_READ,
		ST_EVAL,
		ST_FIRE,
		ST_FLUSH
	} ast_state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [6:0]  day_field;
		logic [1:0]  entry_flags;
		logic [8:0]  actions;
		logic [6:0]  temp_value;
		logic [15:0] entry_id;
		logic        power_is_on;
	} ast_in_t;

	typedef struct packed {
		logic [3:0]  command;
		logic [6:0]  command_value;
		logic [1:0]  status;
		logic [15:0] assigned_id;
		logic        last;
	} ast_out_t;

	typedef struct packed {
		logic [15:0] id;
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [6:0]  mask;
		logic        enabled;
		logic        recurring;
		logic [8:0]  acts;
		logic [6:0]  temp;
	} ast_entry_t;

	// beat request from the sequencer to the output stage
	typedef struct packed {
		logic     push;
		logic     flush;
		ast_out_t beat;
	} ast_emit_req_t;

	typedef struct packed {
		logic stall;
		logic pend;
	} ast_emit_sts_t;

endpackage

FILE: hdl/alarm_schedule_table_unit.sv
// Top level of the alarm schedule table: sequencer over the entry RAM.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+---------------------------------
//  req     | in  | req_valid/req_ready  | req_data  (ast_in_t)
//  rsp     | out | rsp_valid/rsp_ready  | rsp_data  (ast_out_t), several beats
//
// One item at a time. Add: status beat and RAM write, then flush. Edits and ticks
// scan the stored entries (RAM read, then evaluate and write back) and fire each command beat in turn.
// Reset clears count and next id and sets last minute to none; the entry RAM
// holds no reset state, since only entries below the count are ever read.
// A held output beat stalls beat generation only; req_ready rises again as
// soon as the last beat sits in the output register.
module alarm_schedule_table_unit import ast_pkg::*; #(
	parameter int MAX_ENTRIES = 10
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ast_in_t  req_data,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output ast_out_t rsp_data
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);

	ast_state_t    state_q, state_d;
	ast_in_t       in_q;
	logic [CW-1:0] idx_q, idx_d;     // read pointer of the compaction scan
	logic [CW-1:0] wr_q, wr_d;       // write pointer, never ahead of idx
	logic [CW-1:0] count_q, count_d;
	logic [15:0]   next_id_q, next_id_d;
	logic [6:0]    last_min_q, last_min_d;
	logic          found_q, found_d;
	logic [5:0]    gen_q, gen_d;     // pending commands of a fired entry
	logic [8:0]    acts_q;
	logic [6:0]    temp_q;
	logic          fire_ld;

	logic          ram_we, ram_re;
	logic [IW-1:0] ram_waddr, ram_raddr;
	ast_entry_t    ram_wdata, ent;

	ast_emit_req_t emit_req;
	ast_emit_sts_t emit_sts;

	// entry evaluation against the latched item
	logic       tmatch, rec_hit, date_hit, hit, id_hit, wants_on, pwr_eff;
	logic [7:0] mask_ext;
	logic [5:0] gen_new;
	ast_out_t   fire_beat, status_beat;

	ast_ram #(
		.WIDTH($bits(ast_entry_t)),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ent)
	);

	ast_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (emit_req),
		.sts      (emit_sts),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	assign req_ready = (state_q == ST_IDLE);

	assign mask_ext = {1'b0, ent.mask};
	assign tmatch   = ent.enabled && (ent.hour == in_q.hour) && (ent.minute == in_q.minute);
	assign rec_hit  = (in_q.day_field < {4'd0, WEEKDAYS}) && mask_ext[in_q.day_field[2:0]];
	assign date_hit = (ent.year == in_q.year) && (ent.month == in_q.month)
		&& (ent.day == in_q.day);
	assign hit      = tmatch && (ent.recurring ? rec_hit : date_hit);
	assign id_hit   = (ent.id == in_q.entry_id);

	// auto power-on comes first, then power, filter, heater, bubble, temperature
	assign wants_on = (ent.acts[3:2] == 2'b11) || (ent.acts[5:4] == 2'b11)
		|| (ent.acts[7:6] == 2'b11) || ent.acts[8];
	assign pwr_eff  = in_q.power_is_on || wants_on;
	assign gen_new  = {pwr_eff && ent.acts[8], pwr_eff && ent.acts[6],
		pwr_eff && ent.acts[4], pwr_eff && ent.acts[2], ent.acts[0],
		wants_on && !in_q.power_is_on};

	always_comb begin
		fire_beat = '0;
		if (gen_q[0]) begin
			fire_beat.command = CMD_POWER_ON;
		end else if (gen_q[1]) begin
			fire_beat.command = acts_q[1] ? CMD_POWER_ON : CMD_POWER_OFF;
		end else if (gen_q[2]) begin
			fire_beat.command = acts_q[3] ? CMD_FILTER_ON : CMD_FILTER_OFF;
		end else if (gen_q[3]) begin
			fire_beat.command = acts_q[5] ? CMD_HEATER_ON : CMD_HEATER_OFF;
		end else if (gen_q[4]) begin
			fire_beat.command = acts_q[7] ? CMD_BUBBLE_ON : CMD_BUBBLE_OFF;
		end else begin
			fire_beat.command       = CMD_SET_TEMP;
			fire_beat.command_value = temp_q;
		end
	end

	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		wr_d       = wr_q;
		count_d    = count_q;
		next_id_d  = next_id_q;
		last_min_d = last_min_q;
		found_d    = found_q;
		gen_d      = gen_q;
		fire_ld    = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = wr_q[IW-1:0];
		ram_raddr  = idx_q[IW-1:0];
		ram_wdata  = ent;
		emit_req   = '0;
		status_beat         = '0;
		status_beat.command = CMD_STATUS;
		status_beat.status  = found_q ? STS_OK : STS_NOT_FOUND;

		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				idx_d   = '0;
				wr_d    = '0;
				found_d = 1'b0;
				case (in_q.kind)
					KIND_TICK: begin
						if ({1'b0, in_q.minute} == last_min_q) begin
							state_d = ST_IDLE;
						end else begin
							last_min_d = {1'b0, in_q.minute};
							state_d = (in_q.year < YEAR_FLOOR) ? ST_IDLE : ST_READ;
						end
					end
					KIND_ADD: begin
						// output stage is empty here, the push never stalls
						emit_req.push = 1'b1;
						if (count_q >= CNT_MAX) begin
							status_beat.status = STS_FULL;
						end else begin
							status_beat.status      = STS_OK;
							status_beat.assigned_id = next_id_q;
							ram_we    = 1'b1;
							ram_waddr = count_q[IW-1:0];
							ram_wdata = '{id: next_id_q, year: in_q.year, month: in_q.month,
								day: in_q.day, hour: in_q.hour, minute: in_q.minute,
								mask: in_q.day_field, enabled: in_q.entry_flags[0],
								recurring: in_q.entry_flags[1], acts: in_q.actions,
								temp: in_q.temp_value};
							count_d   = count_q + 1'b1;
							next_id_d = next_id_q + 16'd1;
						end
						emit_req.beat = status_beat;
						state_d = ST_FLUSH;
					end
					default: begin
						state_d = ST_READ;
					end
				endcase
			end
			ST_READ: begin
				if (idx_q < count_q) begin
					ram_re  = 1'b1;
					state_d = ST_EVAL;
				end else if (in_q.kind == KIND_TICK) begin
					count_d = wr_q;
					state_d = ST_FLUSH;
				end else begin
					emit_req.push = 1'b1;
					emit_req.beat = status_beat;
					if (!emit_sts.stall) begin
						count_d = wr_q;
						state_d = ST_FLUSH;
					end
				end
			end
			ST_EVAL: begin
				idx_d   = idx_q + 1'b1;
				state_d = ST_READ;
				ram_we  = 1'b1;
				wr_d    = wr_q + 1'b1;
				case (in_q.kind)
					KIND_TICK: begin
						if (hit) begin
							gen_d   = gen_new;
							fire_ld = 1'b1;
							if (gen_new != '0) begin
								state_d = ST_FIRE;
							end
							// a fired one-shot entry is dropped from the table
							if (!ent.recurring) begin
								ram_we = 1'b0;
								wr_d   = wr_q;
							end
						end
					end
					KIND_DELETE: begin
						if (id_hit) begin
							found_d = 1'b1;
							ram_we  = 1'b0;
							wr_d    = wr_q;
						end
					end
					default: begin
						if (id_hit && !found_q) begin
							found_d = 1'b1;
							ram_wdata.enabled = in_q.entry_flags[0];
						end
					end
				endcase
			end
			ST_FIRE: begin
				emit_req.push = 1'b1;
				emit_req.beat = fire_beat;
				if (!emit_sts.stall) begin
					gen_d = gen_q & (gen_q - 6'd1);
					if ((gen_q & (gen_q - 6'd1)) == '0) begin
						state_d = ST_READ;
					end
				end
			end
			ST_FLUSH: begin
				emit_req.flush = 1'b1;
				if (!emit_sts.stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			wr_q       <= '0;
			count_q    <= '0;
			next_id_q  <= '0;
			last_min_q <= MINUTE_NONE;
			found_q    <= 1'b0;
			gen_q      <= '0;
		end else begin
			state_q    <= state_d;
			idx_q      <= idx_d;
			wr_q       <= wr_d;
			count_q    <= count_d;
			next_id_q  <= next_id_d;
			last_min_q <= last_min_d;
			found_q    <= found_d;
			gen_q      <= gen_d;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			in_q <= req_data;
		end
		if (fire_ld) begin
			acts_q <= ent.acts;
			temp_q <= ent.temp;
		end
	end

	// no beat may be held back once a new item can enter
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !emit_sts.pend)
		else $error("beat still pending while idle");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("entry count above table depth");

	// compaction writes only entries already read
	a_wr_behind: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ || state_q == ST_EVAL || state_q == ST_FIRE)
		|-> ((wr_q <= idx_q) && (idx_q <= count_q)))
		else $error("scan pointers out of order");

	a_fire_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRE) |-> (gen_q != '0))
		else $error("fire state with no command pending");

endmodule

FILE: hdl/ast_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ast_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/ast_emit.sv
// Output stage: holds one beat back so the final beat can be marked last.
module ast_emit import ast_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  ast_emit_req_t req,
	output ast_emit_sts_t sts,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ast_out_t      rsp_data
);

	logic     pend_q;
	ast_out_t pend_beat_q;
	logic     ov_q;
	ast_out_t out_q;
	logic     slot_free;
	logic     send;
	ast_out_t send_beat;

	assign slot_free = !ov_q || rsp_ready;
	assign sts.stall = (req.push || req.flush) && pend_q && !slot_free;
	assign sts.pend  = pend_q;
	// the held beat moves out when something follows it or the item ends, once the output register is free
	assign send      = (req.push || req.flush) && pend_q && slot_free;

	always_comb begin
		send_beat      = pend_beat_q;
		send_beat.last = req.flush && !req.push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			ov_q   <= 1'b0;
		end else begin
			if (send) begin
				ov_q <= 1'b1;
			end else if (rsp_ready) begin
				ov_q <= 1'b0;
			end
			if (req.push && !sts.stall) begin
				pend_q <= 1'b1;
			end else if (req.flush && send) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (send) begin
			out_q <= send_beat;
		end
		if (req.push && !sts.stall) begin
			pend_beat_q <= req.beat;
		end
	end

	assign rsp_valid = ov_q;
	assign rsp_data  = out_q;

endmodule
